[src/pwsh_pkg.sv]
// ----------------------------------------------------------------------------
// pwsh_pkg: shared types and constants of the phased ramp waveshaper
// Fixed-point formats, polynomial coefficients, register indexes, the payloads
// of the log2, exp2 and sine stages and a truncating division helper.
// ----------------------------------------------------------------------------
package pwsh_pkg;

  // Phase fraction bits (Q0.16 phase) and pipeline depth.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int LOG_CELLS       = 16;
  localparam int NUM_STAGES      = 37;

  // Configuration register indexes.
  localparam logic CFG_TILT_KNOB = 1'b0;
  localparam logic CFG_RES_KNOB  = 1'b1;

  // Reciprocal of 625 scaled by 2^32, rounded down.
  localparam logic [22:0] DIV_RECIP = 23'd6871947;

  // Horner coefficients of the 2^y polynomial, Q16.
  localparam logic [17:0] EXP_C_INIT = 18'd87;
  localparam logic [17:0] EXP_C [0:4] = '{18'd630, 18'd3638, 18'd15744, 18'd45426,
                                          18'd65536};

  // Horner coefficients of the odd sine polynomial in t^2, Q16.
  localparam logic signed [19:0] SIN_C_INIT = 20'sd11;
  localparam logic signed [19:0] SIN_C [0:3] = '{-20'sd307, 20'sd5223, -20'sd42334,
                                                 20'sd102944};

  // Payload of one log2 squaring cell.
  typedef struct packed {
    logic [16:0] m;
    logic [15:0] frac;
    logic [4:0]  n;
    logic [16:0] tilt_c;
    logic [16:0] r;
  } lg_t;

  // Payload of one exp2 polynomial stage.
  typedef struct packed {
    logic [17:0] acc;
    logic [16:0] y;
    logic [4:0]  ip;
    logic        fz;
    logic [16:0] r;
  } ex_t;

  // Payload of one sine polynomial stage.
  typedef struct packed {
    logic signed [19:0] acc;
    logic [16:0]        t2;
    logic [16:0]        t;
    logic               neg;
    logic [16:0]        r;
  } sn_t;

  // Signed division by 65536 that truncates toward zero.
  function automatic logic signed [23:0] tdiv16(input logic signed [39:0] p);
    logic [39:0] a;
    logic [23:0] q;
    a = p[39] ? 40'(-p) : 40'(p);
    q = a[39:16];
    return p[39] ? 24'(-q) : q;
  endfunction

endpackage

[src/pwsh_div625.sv]
// ----------------------------------------------------------------------------
// pwsh_div625: two-stage divider by the constant 625
// A reciprocal multiply gives an estimate that is low by at most one; the
// second stage corrects it with a single compare of the remainder.
// ----------------------------------------------------------------------------
module pwsh_div625 (
  input  logic        clk,
  input  logic        adv,
  input  logic [28:0] n,
  output logic [19:0] q
);
  import pwsh_pkg::*;

  logic [51:0] prod;
  logic [19:0] est;
  logic [28:0] n1;
  logic [29:0] rem;

  // Reciprocal estimate.
  assign prod = 52'(n) * 52'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      est <= prod[51:32];
      n1  <= n;
    end
  end

  // Remainder correction.
  assign rem = 30'(n1) - 30'(est) * 30'd625;

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= est + 20'(rem >= 30'd625);
    end
  end

endmodule

[src/pwsh_log_cell.sv]
// ----------------------------------------------------------------------------
// pwsh_log_cell: one fraction bit of the log2 chain
// Squares the Q1.16 mantissa and shifts out one bit of the logarithm's
// fraction, passing the rest of the item on to the next cell.
// ----------------------------------------------------------------------------
module pwsh_log_cell (
  input  logic             clk,
  input  logic             adv,
  input  pwsh_pkg::lg_t    d,
  output pwsh_pkg::lg_t    q
);
  import pwsh_pkg::*;

  logic [33:0] sq_full;
  logic [17:0] sq;
  lg_t         q_next;

  // Square and renormalize to [1, 2).
  always_comb begin
    sq_full = 34'(d.m) * 34'(d.m);
    sq      = sq_full[33:16];
    q_next  = d;
    if (sq[17]) begin
      q_next.m    = sq[17:1];
      q_next.frac = {d.frac[14:0], 1'b1};
    end else begin
      q_next.m    = sq[16:0];
      q_next.frac = {d.frac[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

[src/phased_ramp_waveshaper.sv]
// ----------------------------------------------------------------------------
// phased_ramp_waveshaper: ramp-driven phase-distorting sine shaper
// Maps ramp, tilt and resolution to a reshaped phase, takes its sine and
// windows it by a triangle and a falling saw.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (ramp_mv, tilt_cv_mv, res_cv_mv) enter on in_valid/in_stall,
//   result items (tri_out_mv, saw_out_mv, first_half_light) leave on
//   out_valid/out_stall. The knobs are written through cfg_we, cfg_index and
//   cfg_data while no item is in flight.
//   The datapath is a 37-stage pipeline: input saturation, constant dividers,
//   phase product, normalization, a chain of 16 log2 squaring cells, the
//   exponent product, five exp2 polynomial stages, four sine polynomial stages
//   and the output scaling. One item is accepted every cycle unless a stalled
//   result holds the pipeline; the number of stages sets the latency, and
//   each log2 cell holds one squaring multiplier.
//   When out_stall is high with a result waiting, the whole pipeline holds and
//   in_stall rises in the same cycle. Reset clears all valid flags and sets
//   both knobs to zero.
// ----------------------------------------------------------------------------
module phased_ramp_waveshaper (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [13:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] ramp_mv,
  input  logic signed [14:0] tilt_cv_mv,
  input  logic signed [14:0] res_cv_mv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] tri_out_mv,
  output logic signed [13:0] saw_out_mv,
  output logic               first_half_light
);
  import pwsh_pkg::*;

  logic                  adv;
  logic [NUM_STAGES-1:0] vld;
  logic [13:0]           tilt_knob_mv;
  logic [13:0]           res_knob_mv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_knob_mv <= '0;
      res_knob_mv  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILT_KNOB: tilt_knob_mv <= cfg_data;
        CFG_RES_KNOB:  res_knob_mv  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register is free.
  assign adv      = !vld[NUM_STAGES-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // Stage 0: saturate knob plus CV and clamp the ramp.
  logic signed [16:0] tsum_s, rsum_s, ramp_s;
  logic [13:0]        tsum_c, rsum_c, ramp_cc;
  logic [13:0]        tsum, rsum, ramp_c;

  always_comb begin
    tsum_s = $signed({3'b0, tilt_knob_mv}) + 17'(tilt_cv_mv);
    rsum_s = $signed({3'b0, res_knob_mv}) + 17'(res_cv_mv);
    ramp_s = 17'(ramp_mv);
    tsum_c  = (tsum_s < 0) ? 14'd0 : (tsum_s > 17'sd10000) ? 14'd10000 : tsum_s[13:0];
    rsum_c  = (rsum_s < 0) ? 14'd0 : (rsum_s > 17'sd10000) ? 14'd10000 : rsum_s[13:0];
    ramp_cc = (ramp_s < 0) ? 14'd0 : (ramp_s > 17'sd10000) ? 14'd10000 : ramp_s[13:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tsum   <= tsum_c;
      rsum   <= rsum_c;
      ramp_c <= ramp_cc;
    end
  end

  // Stages 1-2: divide by 625 to reach Q16 phase, tilt and resolution step.
  logic [19:0] q_r, q_t, q_res;

  pwsh_div625 u_div_r (.clk(clk), .adv(adv), .n(29'({ramp_c, 12'b0})), .q(q_r));
  pwsh_div625 u_div_t (.clk(clk), .adv(adv), .n(29'({tsum, 12'b0})), .q(q_t));
  pwsh_div625 u_div_res (.clk(clk), .adv(adv), .n(29'(rsum) * 29'd28672), .q(q_res));

  // Stage 3: one minus the fractional part of phase times resolution, one minus tilt.
  logic [19:0] res_q;
  logic [36:0] ph_prod;
  logic [16:0] x3, r3, tc3;

  assign res_q   = 20'd65536 + q_res;
  assign ph_prod = 37'(q_r[16:0]) * 37'(res_q);

  always_ff @(posedge clk) begin
    if (adv) begin
      x3  <= 17'd65536 - 17'(ph_prod[31:16]);
      r3  <= q_r[16:0];
      tc3 <= 17'd65536 - q_t[16:0];
    end
  end

  // Stage 4: find the leading one and normalize the mantissa.
  logic [4:0] msb;
  lg_t        lg [0:LOG_CELLS];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 17; i++) begin
      if (x3[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lg[0].m      <= 17'(x3 << (5'd16 - msb));
      lg[0].frac   <= '0;
      lg[0].n      <= msb;
      lg[0].tilt_c <= tc3;
      lg[0].r      <= r3;
    end
  end

  // Stages 5-20: chain of squaring cells, one fraction bit each.
  for (genvar c = 0; c < LOG_CELLS; c++) begin : g_log
    pwsh_log_cell u_cell (.clk(clk), .adv(adv), .d(lg[c]), .q(lg[c+1]));
  end

  // Stage 21: exponent P = -log2(x) * (1 - tilt).
  logic [20:0] lgv;
  logic [37:0] p_prod;
  logic [20:0] p21;
  logic [16:0] r21;

  assign lgv    = {5'(5'd16 - lg[LOG_CELLS].n), 16'b0} - 21'(lg[LOG_CELLS].frac);
  assign p_prod = 38'(lgv) * 38'(lg[LOG_CELLS].tilt_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      p21 <= p_prod[36:16];
      r21 <= lg[LOG_CELLS].r;
    end
  end

  // Stages 22-26: Horner steps of the 2^y polynomial.
  ex_t ex [0:4];

  for (genvar j = 0; j < 5; j++) begin : g_exp
    logic [17:0] acc_in;
    logic [16:0] y_in;
    logic [34:0] e_prod;
    ex_t         e_next;

    always_comb begin
      if (j == 0) begin
        acc_in    = EXP_C_INIT;
        y_in      = 17'd65536 - 17'(p21[15:0]);
        e_next.ip = p21[20:16];
        e_next.fz = (p21[15:0] == 16'd0);
        e_next.r  = r21;
      end else begin
        acc_in    = ex[(j > 0) ? j-1 : 0].acc;
        y_in      = ex[(j > 0) ? j-1 : 0].y;
        e_next.ip = ex[(j > 0) ? j-1 : 0].ip;
        e_next.fz = ex[(j > 0) ? j-1 : 0].fz;
        e_next.r  = ex[(j > 0) ? j-1 : 0].r;
      end
      e_prod     = 35'(acc_in) * 35'(y_in);
      e_next.y   = y_in;
      e_next.acc = 18'(EXP_C[j] + 18'(e_prod[34:16]));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex[j] <= e_next;
      end
    end
  end

  // Stage 27: reshaped phase k, table index and folded quarter-wave angle.
  logic [16:0] k27;
  logic [9:0]  idx;
  logic [13:0] quad_pos;
  logic [16:0] t27, r27;
  logic        neg27;

  always_comb begin
    if (ex[4].fz) begin
      k27 = 17'd65536 >> ex[4].ip;
    end else begin
      k27 = 17'(ex[4].acc >> (5'd1 + ex[4].ip));
    end
    idx      = k27[15:6];
    quad_pos = {idx[7:0], 6'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t27   <= idx[8] ? 17'({15'd16384 - 15'(quad_pos), 2'b0}) : 17'({quad_pos, 2'b0});
      neg27 <= idx[9];
      r27   <= ex[4].r;
    end
  end

  // Stage 28: t squared.
  logic [33:0] t_sq;
  sn_t         sn [0:4];

  assign t_sq = 34'(t27) * 34'(t27);

  always_ff @(posedge clk) begin
    if (adv) begin
      sn[0].acc <= SIN_C_INIT;
      sn[0].t2  <= t_sq[32:16];
      sn[0].t   <= t27;
      sn[0].neg <= neg27;
      sn[0].r   <= r27;
    end
  end

  // Stages 29-32: Horner steps of the sine polynomial.
  for (genvar j = 0; j < 4; j++) begin : g_sin
    logic signed [39:0] s_prod;
    sn_t                s_next;

    always_comb begin
      s_next     = sn[j];
      s_prod     = 40'(sn[j].acc) * 40'($signed({1'b0, sn[j].t2}));
      s_next.acc = 20'(24'(SIN_C[j]) + tdiv16(s_prod));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sn[j+1] <= s_next;
      end
    end
  end

  // Stage 33: final product with t and clamp to 0..1.
  logic signed [39:0] f_prod;
  logic signed [23:0] s_val;
  logic [16:0]        mag33, r33;
  logic               neg33;

  assign f_prod = 40'($signed({1'b0, sn[4].t})) * 40'(sn[4].acc);
  assign s_val  = tdiv16(f_prod);

  always_ff @(posedge clk) begin
    if (adv) begin
      mag33 <= (s_val < 0) ? 17'd0 : (s_val > 24'sd65536) ? 17'd65536 : s_val[16:0];
      neg33 <= sn[4].neg;
      r33   <= sn[4].r;
    end
  end

  // Stage 34: apply the triangle and saw windows.
  logic [16:0] r_c, r_min, w_tri;
  logic [33:0] a_tri, a_saw;
  logic        neg34, half34;

  always_comb begin
    r_c   = 17'd65536 - r33;
    r_min = (r33 < r_c) ? r33 : r_c;
    w_tri = 17'({r_min, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tri  <= 34'(mag33) * 34'(w_tri);
      a_saw  <= 34'(mag33) * 34'(r_c);
      neg34  <= neg33;
      half34 <= (r33 < 17'd32768);
    end
  end

  // Stage 35: scale to millivolts.
  logic [46:0] b_tri, b_saw;
  logic        neg35, half35;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tri  <= 47'(a_tri) * 47'd5000;
      b_saw  <= 47'(a_saw) * 47'd5000;
      neg35  <= neg34;
      half35 <= half34;
    end
  end

  // Stage 36: round to nearest, limit and restore the sign.
  logic [47:0] rnd_tri, rnd_saw;
  logic [15:0] q_tri, q_saw;
  logic [13:0] m_tri, m_saw;

  always_comb begin
    rnd_tri = 48'(b_tri) + 48'h0000_8000_0000;
    rnd_saw = 48'(b_saw) + 48'h0000_8000_0000;
    q_tri   = rnd_tri[47:32];
    q_saw   = rnd_saw[47:32];
    m_tri   = (q_tri > 16'd5000) ? 14'd5000 : q_tri[13:0];
    m_saw   = (q_saw > 16'd5000) ? 14'd5000 : q_saw[13:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri_out_mv       <= neg35 ? 14'(-m_tri) : m_tri;
      saw_out_mv       <= neg35 ? 14'(-m_saw) : m_saw;
      first_half_light <= half35;
    end
  end

  assign out_valid = vld[NUM_STAGES-1];

  // Results stay within the +-5 V range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tri_out_mv >= -14'sd5000 && tri_out_mv <= 14'sd5000 &&
                   saw_out_mv >= -14'sd5000 && saw_out_mv <= 14'sd5000))
    else $error("output outside +-5000 mV");

  // The valid line is empty after reset.
  a_reset: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // A stalled result freezes the valid flags of every stage of the pipeline.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while output stalled");

  // In the second half both windowed outputs agree in sign.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !first_half_light) |->
      ((tri_out_mv >= 0 && saw_out_mv >= 0) || (tri_out_mv <= 0 && saw_out_mv <= 0)))
    else $error("window outputs disagree in sign");

endmodule

[tb/phased_ramp_waveshaper_tb.sv]
// ----------------------------------------------------------------------------
// phased_ramp_waveshaper_tb: self-checking bench of the ramp waveshaper
// Drives directed and random samples under several knob settings and idle
// patterns, predicts each result in fixed point and checks it in order.
// ----------------------------------------------------------------------------

// Expected results of accepted samples, oldest first.
class shaper_scoreboard;
  logic signed [13:0] tri_q[$];
  logic signed [13:0] saw_q[$];
  logic               light_q[$];
  int                 errors;

  // Queue the expected result of one accepted sample.
  function void note_sample(logic signed [13:0] t, logic signed [13:0] s, logic l);
    tri_q.push_back(t);
    saw_q.push_back(s);
    light_q.push_back(l);
  endfunction

  function int pending();
    return tri_q.size();
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Compare one delivered result with the oldest expectation.
  task check_result(logic signed [13:0] t, logic signed [13:0] s, logic l);
    logic signed [13:0] et, es;
    logic               el;
    if (tri_q.size() == 0) begin
      report("result with no sample outstanding");
      return;
    end
    et = tri_q.pop_front();
    es = saw_q.pop_front();
    el = light_q.pop_front();
    if (t !== et) report($sformatf("tri_out_mv got %0d want %0d", t, et));
    if (s !== es) report($sformatf("saw_out_mv got %0d want %0d", s, es));
    if (l !== el) report($sformatf("first_half_light got %0b want %0b", l, el));
  endtask
endclass

module phased_ramp_waveshaper_tb;
  import pwsh_pkg::*;

  localparam int LATENCY   = 37;
  localparam int MAX_CYCLE = 400000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [13:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [14:0] ramp_mv;
  logic signed [14:0] tilt_cv_mv;
  logic signed [14:0] res_cv_mv;
  logic               out_valid;
  logic               out_stall;
  logic signed [13:0] tri_out_mv;
  logic signed [13:0] saw_out_mv;
  logic               first_half_light;

  shaper_scoreboard sb;
  logic [13:0]      tilt_knob;
  logic [13:0]      res_knob;
  int               send_idle_pct;
  int               stall_pct;
  int               phase_num;
  int               hold_left;
  logic             hold_done;
  longint           cycle = 0;

  phased_ramp_waveshaper u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .ramp_mv(ramp_mv),
    .tilt_cv_mv(tilt_cv_mv), .res_cv_mv(res_cv_mv), .out_valid(out_valid),
    .out_stall(out_stall), .tri_out_mv(tri_out_mv), .saw_out_mv(saw_out_mv),
    .first_half_light(first_half_light)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Knob plus CV, saturated to 0..10000 mV.
  function automatic longint knob_sum(logic [13:0] knob, logic signed [14:0] cv);
    longint s;
    s = longint'(knob) + longint'(cv);
    if (s < 0) s = 0;
    if (s > 10000) s = 10000;
    return s;
  endfunction

  // -log2(x / 2^16) in Q.16 by repeated squaring of the mantissa.
  function automatic longint neg_log2_q16(longint x);
    int     msb;
    longint m, fr;
    msb = 0;
    fr  = 0;
    while ((x >> (msb + 1)) != 0) msb++;
    m = (x << 16) >> msb;
    for (int j = 0; j < 16; j++) begin
      m = (m * m) >> 16;
      fr = fr << 1;
      if (m >= 131072) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return longint'(PHASE_FRAC_BITS - msb) * 65536 - fr;
  endfunction

  // 2^(-p/65536) in Q0.16 through the degree-5 polynomial.
  function automatic longint exp2_neg_q16(longint p);
    longint ip, f, y, acc;
    ip = p >> 16;
    f  = p & 16'hFFFF;
    if (ip > 40) return 0;
    if (f == 0) return (longint'(1) << PHASE_FRAC_BITS) >> ip;
    y = 65536 - f;
    acc = 87;
    acc = 630 + ((acc * y) >> 16);
    acc = 3638 + ((acc * y) >> 16);
    acc = 15744 + ((acc * y) >> 16);
    acc = 45426 + ((acc * y) >> 16);
    acc = 65536 + ((acc * y) >> 16);
    return (acc << PHASE_FRAC_BITS) >> (17 + ip);
  endfunction

  // sin(2*pi*k) in Q16 from a 1024-entry phase grid and an odd polynomial.
  function automatic longint sine_of_turns(longint k);
    longint idx, ph, quad, wq, t, t2, acc, s;
    idx  = ((k * 1024) >> PHASE_FRAC_BITS) % 1024;
    ph   = (idx * 65536) / 1024;
    quad = (ph >> 14) & 3;
    wq   = ph & 16'h3FFF;
    t    = ((quad & 1) != 0 ? (16384 - wq) : wq) << 2;
    t2   = (t * t) / 65536;
    acc  = 11;
    acc  = -307 + (acc * t2) / 65536;
    acc  = 5223 + (acc * t2) / 65536;
    acc  = -42334 + (acc * t2) / 65536;
    acc  = 102944 + (acc * t2) / 65536;
    s    = (t * acc) / 65536;
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    return (quad & 2) != 0 ? -s : s;
  endfunction

  // Window and scale to millivolts, rounding ties away from zero.
  function automatic logic signed [13:0] window_mv(longint s, longint w);
    longint mag, q;
    mag = (s < 0 ? -s : s) * w * 5000;
    q = (mag + (longint'(1) << 31)) >> 32;
    if (q > 5000) q = 5000;
    if (s < 0) q = -q;
    return 14'(q);
  endfunction

  // Predict one result from a sample and the current knobs.
  task automatic predict_shaper(input logic signed [14:0] rmp, input logic signed [14:0] tcv,
                                input logic signed [14:0] rcv);
    longint one, ramp, tsum, rsum, res, tilt, r, u, p, k, s, wtri;
    one  = longint'(1) << PHASE_FRAC_BITS;
    tsum = knob_sum(tilt_knob, tcv);
    rsum = knob_sum(res_knob, rcv);
    res  = 65536 + (rsum * 7 * 65536) / 10000;
    tilt = (tsum * 65536) / 10000;
    ramp = rmp;
    if (ramp < 0) ramp = 0;
    if (ramp > 10000) ramp = 10000;
    r = (ramp * one) / 10000;
    u = ((r * res) >> 16) & (one - 1);
    p = (neg_log2_q16(one - u) * (65536 - tilt)) >> 16;
    k = exp2_neg_q16(p);
    s = sine_of_turns(k);
    wtri = 2 * (r < one - r ? r : one - r);
    sb.note_sample(window_mv(s, wtri), window_mv(s, one - r), r < (one >> 1));
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Input acceptance feeds the predictor; output acceptance is checked.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_shaper(ramp_mv, tilt_cv_mv, res_cv_mv);
    if (!rst && out_valid && !out_stall)
      sb.check_result(tri_out_mv, saw_out_mv, first_half_light);
  end

  // Receiver: random stalls, and one long hold-off in phase 4.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase_num == 4) begin
      out_stall <= 1'b1;
      hold_left <= 149;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_knob(input logic idx, input logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TILT_KNOB) tilt_knob = val;
    else res_knob = val;
    @(posedge clk);
  endtask

  // Offer one sample, with random idle cycles first, and wait for acceptance.
  task automatic send_sample(input logic signed [14:0] rmp, input logic signed [14:0] tcv,
                             input logic signed [14:0] rcv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    ramp_mv    <= rmp;
    tilt_cv_mv <= tcv;
    res_cv_mv  <= rcv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Random millivolt value: mostly in range, sometimes anywhere in 15 bits.
  function automatic logic signed [14:0] rand_mv();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(20000)) - 10000);
  endfunction

  initial begin
    logic signed [14:0] edge_mv [0:6];
    logic [13:0]        knob_set [0:5];
    sb = new();
    edge_mv = '{-15'sd16384, -15'sd10000, 15'sd0, 15'sd1, 15'sd5000, 15'sd10000,
                15'sd16383};
    knob_set = '{14'd0, 14'd10000, 14'd5000, 14'd16383, 14'd2500, 14'd7777};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TILT_KNOB;
    cfg_data = '0;
    in_valid = 1'b0;
    ramp_mv = '0;
    tilt_cv_mv = '0;
    res_cv_mv = '0;
    phase_num = -1;
    send_idle_pct = 0;
    stall_pct = 0;
    tilt_knob = '0;
    res_knob = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, full tilt, half ramp, saturation of knob plus CV.
    for (int i = 0; i < 7; i++) send_sample(edge_mv[i], 15'sd0, 15'sd0);
    send_sample(15'sd3000, 15'sd10000, 15'sd0);
    send_sample(15'sd3000, -15'sd16384, 15'sd16383);
    send_sample(15'sd4999, 15'sd2000, 15'sd10000);
    send_sample(15'sd5001, 15'sd16383, -15'sd10000);
    send_sample(15'sd7300, 15'sd5000, 15'sd5000);
    drain();
    write_knob(CFG_TILT_KNOB, 14'd10000);
    write_knob(CFG_RES_KNOB, 14'd10000);
    send_sample(15'sd2500, 15'sd0, 15'sd0);
    send_sample(15'sd2500, -15'sd10000, -15'sd10000);
    send_sample(15'sd8000, 15'sd10000, 15'sd10000);
    drain();

    // Random phases over knob settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_knob(CFG_TILT_KNOB, knob_set[ph]);
      write_knob(CFG_RES_KNOB, knob_set[5 - ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      phase_num = ph;
      for (int i = 0; i < 165; i++) send_sample(rand_mv(), rand_mv(), rand_mv());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
